>>> rtl/hte_pkg.sv
// Shared types and constants for the Huffman table encoder.
// No dependencies; every other file in rtl/ refers to this package.
`default_nettype none

package hte_pkg;

    localparam int BYTE_BITS = 8;
    localparam int CODE_W    = 32;
    localparam int LEN_W     = 6;
    localparam int PEND_W    = 7;
    localparam int ACC_W     = PEND_W + CODE_W;
    localparam int CNT_W     = 6;
    localparam int VBITS_W   = 4;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } opcode_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [7:0]        symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } cmd_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] out_byte;
        logic [VBITS_W-1:0]   valid_bits;
        logic                 last;
    } res_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } entry_t;

    // Lookup stage to packer: what the registered item asks for
    typedef struct packed {
        logic              is_encode;
        logic              is_flush;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } lookup_t;

endpackage

`default_nettype wire

>>> rtl/hte_cmd_if.sv
// Command channel of the Huffman table encoder: valid/ready plus one command.
// Depends on hte_pkg for the payload type.
`default_nettype none

interface hte_cmd_if;
    logic          valid;
    logic          ready;
    hte_pkg::cmd_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/hte_res_if.sv
// Result channel of the Huffman table encoder: valid/ready plus one packed byte.
// Depends on hte_pkg for the payload type.
`default_nettype none

interface hte_res_if;
    logic          valid;
    logic          ready;
    hte_pkg::res_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/hte_table.sv
// Code table and lookup register: writes loads, reads the entry for encodes.
// Depends on hte_pkg and hte_cmd_if.
`default_nettype none

module hte_table #(
    parameter int SYMBOL_COUNT = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    hte_cmd_if.sink               cmd,
    output hte_pkg::lookup_t      lk,
    output logic                  lk_valid,
    input  wire logic             lk_take
);

    localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    hte_pkg::entry_t mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] vld_reg;

    logic            s1_vld_reg;
    logic            flush_reg;
    logic            hit_reg;
    hte_pkg::entry_t ent_reg;

    logic            accept;
    logic            in_range;
    logic            len_ok;
    logic            wr_en;
    logic [IDX_W-1:0] addr;
    hte_pkg::entry_t wdata;
    logic [hte_pkg::CODE_W-1:0] code_mask;

    assign cmd.ready = !s1_vld_reg || lk_take;
    assign accept    = cmd.valid && cmd.ready;
    assign addr      = cmd.payload.symbol[IDX_W-1:0];
    assign in_range  = {1'b0, cmd.payload.symbol} < 9'(SYMBOL_COUNT);
    assign len_ok    = ({1'b0, cmd.payload.code_length} <= 7'(MAX_CODE_LEN))
                    && (cmd.payload.code_length <= 6'(hte_pkg::CODE_W));
    // Keep only the low code_length bits of the code
    assign code_mask = ~({hte_pkg::CODE_W{1'b1}} << cmd.payload.code_length);
    assign wdata.code = cmd.payload.code_bits & code_mask;
    assign wdata.len  = cmd.payload.code_length;
    assign wr_en = accept && (cmd.payload.opcode == hte_pkg::OP_LOAD) && in_range && len_ok;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (accept)
        begin
            ent_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            s1_vld_reg <= 1'b0;
            flush_reg  <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[addr] <= 1'b1;
            end
            if (accept)
            begin
                s1_vld_reg <= 1'b1;
                flush_reg  <= cmd.payload.opcode == hte_pkg::OP_FLUSH;
                hit_reg    <= (cmd.payload.opcode == hte_pkg::OP_ENCODE) && in_range
                              && vld_reg[addr];
            end
            else if (lk_take)
            begin
                s1_vld_reg <= 1'b0;
            end
        end
    end

    assign lk_valid     = s1_vld_reg;
    assign lk.is_encode = hit_reg && (ent_reg.len != '0);
    assign lk.is_flush  = flush_reg;
    assign lk.code      = ent_reg.code;
    assign lk.len       = ent_reg.len;

endmodule

`default_nettype wire

>>> rtl/hte_packer.sv
// Bit accumulator and output register: appends codes MSB first, emits bytes.
// Depends on hte_pkg and hte_res_if.
`default_nettype none

module hte_packer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hte_pkg::lookup_t  lk,
    input  wire logic              lk_valid,
    output logic                   lk_take,
    hte_res_if.source              res
);

    localparam logic [hte_pkg::CNT_W-1:0] BYTE_CNT = hte_pkg::CNT_W'(hte_pkg::BYTE_BITS);

    logic [hte_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [hte_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    hte_pkg::res_t              res_reg, res_next;
    logic                       out_vld_reg;

    logic                       out_free;
    logic [hte_pkg::PEND_W-1:0] pend_mask;
    logic [hte_pkg::PEND_W-1:0] pend;
    logic [hte_pkg::ACC_W-1:0]  new_acc;
    logic [hte_pkg::CNT_W-1:0]  new_cnt;
    logic [hte_pkg::ACC_W-1:0]  wacc;
    logic [hte_pkg::CNT_W-1:0]  wcnt;
    logic [hte_pkg::CNT_W-1:0]  sh;
    logic                       emit_full;
    logic                       emit_part;
    logic                       emit;

    assign out_free  = !out_vld_reg || res.ready;
    assign lk_take   = lk_valid && (cnt_reg < BYTE_CNT) && out_free;

    assign pend_mask = ~({hte_pkg::PEND_W{1'b1}} << cnt_reg[2:0]);
    assign pend      = acc_reg[hte_pkg::PEND_W-1:0] & pend_mask;
    assign new_acc   = (hte_pkg::ACC_W'(pend) << lk.len) | hte_pkg::ACC_W'(lk.code);
    assign new_cnt   = cnt_reg + hte_pkg::CNT_W'(lk.len);

    always_comb
    begin
        wacc      = acc_reg;
        wcnt      = cnt_reg;
        emit_full = 1'b0;
        emit_part = 1'b0;
        if (cnt_reg >= BYTE_CNT)
        begin
            // drain completed bytes of the current symbol
            emit_full = out_free;
        end
        else if (lk_take)
        begin
            if (lk.is_flush)
            begin
                emit_part = cnt_reg != '0;
            end
            else if (lk.is_encode)
            begin
                wacc      = new_acc;
                wcnt      = new_cnt;
                emit_full = new_cnt >= BYTE_CNT;
            end
        end
        sh = wcnt - BYTE_CNT;
    end

    assign emit = emit_full || emit_part;

    always_comb
    begin
        acc_next = wacc;
        cnt_next = wcnt;
        res_next = res_reg;
        if (emit_full)
        begin
            cnt_next            = sh;
            res_next.out_byte   = hte_pkg::BYTE_BITS'(wacc >> sh);
            res_next.valid_bits = hte_pkg::VBITS_W'(hte_pkg::BYTE_BITS);
            res_next.last       = sh < BYTE_CNT;
        end
        else if (emit_part)
        begin
            acc_next            = '0;
            cnt_next            = '0;
            res_next.out_byte   = {1'b0, pend};
            res_next.valid_bits = {1'b0, cnt_reg[2:0]};
            res_next.last       = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            cnt_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            if (emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign res.valid   = out_vld_reg;
    assign res.payload = res_reg;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 6'd39)
        else $error("pending bit count out of range");

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && res_next.last) |=> (cnt_reg < BYTE_CNT))
        else $error("bytes remain after last byte of transaction");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit_part |=> (cnt_reg == '0) && res.valid && (res.payload.valid_bits != 4'd8))
        else $error("flush did not empty accumulator");

    a_no_emit_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |-> !emit)
        else $error("byte emitted into a stalled output register");
`endif

endmodule

`default_nettype wire

>>> rtl/huffman_table_encoder.sv
// Huffman table encoder top level: code table lookup stage and bit packer.
// Depends on hte_pkg, hte_cmd_if, hte_res_if, hte_table and hte_packer.
//
// Usage:
//   cmd carries one command per transaction: load writes a symbol's code and
//   length into the table (lengths above MAX_CODE_LEN or 32 are dropped),
//   encode appends the symbol's code MSB first, flush emits the partial byte
//   right-aligned with its bit count. res carries one byte per transaction;
//   last marks the final byte caused by a command.
//   Path: the first byte of a command passes the table read register, then
//   the output register, before it appears on res.
//   Throughput: one command per cycle while each yields at most one byte and
//   res is ready; an encode that completes n bytes (at most 4) holds the
//   packer until all are out; the output register takes one byte per cycle.
//   Reset: every table entry reads as having no code, pending bits are
//   dropped and both registers empty; commands are taken right after reset.
//   Stall: while res is held off the output register keeps its byte, the
//   packer and the lookup register wait, and cmd.ready drops once the lookup
//   register is full.
`default_nettype none

module huffman_table_encoder #(
    parameter int SYMBOL_COUNT = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hte_cmd_if.sink    cmd,
    hte_res_if.source  res
);

    hte_pkg::lookup_t lk;
    logic             lk_valid;
    logic             lk_take;

    hte_table #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .lk       (lk),
        .lk_valid (lk_valid),
        .lk_take  (lk_take)
    );

    hte_packer u_packer (
        .clk      (clk),
        .rst_n    (rst_n),
        .lk       (lk),
        .lk_valid (lk_valid),
        .lk_take  (lk_take),
        .res      (res)
    );

endmodule

`default_nettype wire

>>> tb/sv/hte_encode_checker.sv
// Scoreboard for the Huffman table encoder: watches the command and result channels,
// predicts every packed byte and compares it field by field.
// Depends on hte_pkg, hte_cmd_if and hte_res_if.
module hte_encode_checker #(
    parameter int SYMBOL_COUNT = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic clk,
    input  logic rst_n,
    hte_cmd_if   cmd,
    hte_res_if   res,
    output int   fail_count,
    output int   bytes_outstanding
);
    import hte_pkg::*;

    entry_t             code_mem [SYMBOL_COUNT];
    logic [PEND_W-1:0]  carry_bits;
    int                 carry_count;
    res_t               byte_q [$];

    task automatic compare_field(input string name, input int expd, input int act);
        if (expd != act)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, expd, act);
            fail_count++;
        end
    endtask

    // Model one command transaction: update the table or the bit carry, queue the bytes
    task automatic pack_command(input cmd_t c);
        logic [ACC_W-1:0] acc;
        logic [ACC_W-1:0] shifted;
        logic [63:0]      mask;
        int               total;
        int               clen;
        int               n;
        res_t             r;
        case (c.opcode)
            OP_LOAD:
            begin
                if (c.symbol < SYMBOL_COUNT && c.code_length <= MAX_CODE_LEN
                    && c.code_length <= CODE_W)
                begin
                    mask = (64'd1 << c.code_length) - 64'd1;
                    code_mem[c.symbol].code = c.code_bits & mask[CODE_W-1:0];
                    code_mem[c.symbol].len  = c.code_length;
                end
            end
            OP_ENCODE:
            begin
                if (c.symbol < SYMBOL_COUNT && code_mem[c.symbol].len != 0)
                begin
                    clen  = code_mem[c.symbol].len;
                    acc   = ({{CODE_W{1'b0}}, carry_bits} << clen)
                            | {{PEND_W{1'b0}}, code_mem[c.symbol].code};
                    total = carry_count + clen;
                    n     = 0;
                    while (total >= BYTE_BITS && n < 4)
                    begin
                        total         = total - BYTE_BITS;
                        shifted       = acc >> total;
                        r.out_byte    = shifted[BYTE_BITS-1:0];
                        r.valid_bits  = VBITS_W'(BYTE_BITS);
                        r.last        = 1'b0;
                        byte_q.insert(byte_q.size(), r);
                        n++;
                    end
                    if (n > 0)
                        byte_q[byte_q.size()-1].last = 1'b1;
                    carry_count = total & 7;
                    mask        = (64'd1 << carry_count) - 64'd1;
                    carry_bits  = acc[PEND_W-1:0] & mask[PEND_W-1:0];
                end
            end
            OP_FLUSH:
            begin
                if (carry_count != 0)
                begin
                    r.out_byte   = {1'b0, carry_bits};
                    r.valid_bits = VBITS_W'(carry_count);
                    r.last       = 1'b1;
                    byte_q.insert(byte_q.size(), r);
                    carry_bits  = '0;
                    carry_count = 0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t expd;
        if (!rst_n)
        begin
            for (int i = 0; i < SYMBOL_COUNT; i++)
                code_mem[i] = '0;
            carry_bits        = '0;
            carry_count       = 0;
            byte_q.delete();
            fail_count        = 0;
            bytes_outstanding = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (byte_q.size() == 0)
                begin
                    $error("unexpected result byte 0x%0h", res.payload.out_byte);
                    fail_count++;
                end
                else
                begin
                    expd = byte_q.pop_front();
                    compare_field("out_byte", expd.out_byte, res.payload.out_byte);
                    compare_field("valid_bits", expd.valid_bits, res.payload.valid_bits);
                    compare_field("last", expd.last, res.payload.last);
                end
            end
            if (cmd.valid && cmd.ready)
                pack_command(cmd.payload);
            bytes_outstanding = byte_q.size();
        end
    end
endmodule

>>> tb/sv/tb_huffman_table_encoder.sv
// Top of the Huffman table encoder testbench: clock, reset, command stimulus,
// result back-pressure and the verdict. Depends on hte_pkg, both channel
// interfaces, huffman_table_encoder and hte_encode_checker.
module tb_huffman_table_encoder;
    import hte_pkg::*;

    localparam int          SYMBOLS     = 256;
    localparam int          MAX_LEN     = 32;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          RANDOM_CMDS = 145;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic res_rdy = 1'b0;
    logic quiet = 1'b0;
    int   stall_left = 0;
    int   cycle_count = 0;
    int   fail_count;
    int   bytes_outstanding;
    int   coded_syms [$];

    hte_cmd_if cmd_if ();
    hte_res_if res_if ();

    assign res_if.ready = res_rdy;

    huffman_table_encoder #(
        .SYMBOL_COUNT (SYMBOLS),
        .MAX_CODE_LEN (MAX_LEN)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if)
    );

    hte_encode_checker #(
        .SYMBOL_COUNT (SYMBOLS),
        .MAX_CODE_LEN (MAX_LEN)
    ) u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd_if),
        .res               (res_if),
        .fail_count        (fail_count),
        .bytes_outstanding (bytes_outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_huffman_table_encoder: FAIL");
            $finish;
        end
    end

    // Back-pressure in short bursts, with calm stretches in between
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            res_rdy    <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && (cycle_count / 50) % 4 != 3 && $urandom_range(0, 4) == 0)
        begin
            res_rdy    <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end
        else
            res_rdy <= 1'b1;
    end

    // Present one command and hold it until the transaction completes
    task automatic issue(input logic [1:0] op, input logic [7:0] sym,
                         input logic [31:0] bits, input logic [5:0] len);
        cmd_if.valid   <= 1'b1;
        cmd_if.payload <= '{opcode: op, symbol: sym, code_bits: bits, code_length: len};
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        if (op == OP_LOAD && len != 0 && len <= MAX_LEN)
            coded_syms.insert(coded_syms.size(), int'(sym));
    endtask

    task automatic maybe_idle(input int idx);
        if (!quiet && (idx / 16) % 3 != 2 && $urandom_range(0, 3) == 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Hold off the sender until every predicted byte has come out
    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        @(negedge clk);
        while (bytes_outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        int          pick;
        int          kind;
        logic [7:0]  sym;
        logic [5:0]  len;
        cmd_if.valid   = 1'b0;
        cmd_if.payload = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No code loaded yet, empty flush, unused opcode
        issue(OP_ENCODE, 8'h00, 32'h0, 6'd0);
        issue(OP_FLUSH, 8'h00, 32'h0, 6'd0);
        issue(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        // Longest code, one-bit code with junk above it, overlong loads that must not stick
        issue(OP_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
        issue(OP_LOAD, 8'h00, 32'hFFFF_FFFE, 6'd1);
        issue(OP_LOAD, 8'h55, 32'h0000_0016, 6'd5);
        issue(OP_LOAD, 8'h55, 32'h1234_5678, 6'd33);
        issue(OP_LOAD, 8'h55, 32'h0, 6'h3F);
        issue(OP_LOAD, 8'hAA, 32'hFFFF_FF2A, 6'd7);
        maybe_idle(0);
        issue(OP_ENCODE, 8'h00, 32'h0, 6'd0);
        issue(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
        issue(OP_ENCODE, 8'h55, 32'h0, 6'd0);
        issue(OP_FLUSH, 8'h00, 32'h0, 6'd0);
        maybe_idle(1);
        issue(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
        issue(OP_FLUSH, 8'h00, 32'h0, 6'd0);
        // Seven bits carried plus a 32-bit code: four full bytes, seven left to flush
        issue(OP_ENCODE, 8'hAA, 32'h0, 6'd0);
        issue(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
        issue(OP_FLUSH, 8'h00, 32'h0, 6'd0);
        issue(OP_ENCODE, 8'hAA, 32'h0, 6'd0);
        issue(OP_ENCODE, 8'h00, 32'h0, 6'd0);
        // Remove a code, then skip it
        issue(OP_LOAD, 8'h55, 32'hFFFF_FFFF, 6'd0);
        issue(OP_ENCODE, 8'h55, 32'h0, 6'd0);
        issue(OP_ENCODE, 8'h00, 32'h0, 6'd0);
        issue(OP_FLUSH, 8'h00, 32'h0, 6'd0);

        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            if (i == RANDOM_CMDS / 2)
                drain_results();
            if (i == RANDOM_CMDS - 30)
                quiet <= 1'b1;
            pick = $urandom_range(0, 99);
            sym  = 8'($urandom_range(0, 255));
            if (pick < 15)
            begin
                kind = $urandom_range(0, 19);
                if (kind == 0)
                    len = 6'd0;
                else if (kind == 1)
                    len = 6'($urandom_range(33, 63));
                else
                    len = 6'($urandom_range(1, 32));
                issue(OP_LOAD, sym, $urandom(), len);
            end
            else if (pick < 82)
            begin
                if (coded_syms.size() != 0 && $urandom_range(0, 99) < 85)
                    sym = 8'(coded_syms[$urandom_range(0, coded_syms.size() - 1)]);
                issue(OP_ENCODE, sym, $urandom(), 6'($urandom_range(0, 63)));
            end
            else if (pick < 93)
                issue(OP_FLUSH, sym, $urandom(), 6'($urandom_range(0, 63)));
            else
                issue(OP_UNUSED, sym, $urandom(), 6'($urandom_range(0, 63)));
            maybe_idle(i);
        end
        issue(OP_FLUSH, 8'h00, 32'h0, 6'd0);

        drain_results();
        // Let any stray byte from a command without results show up
        repeat (12) @(posedge clk);
        if (fail_count == 0)
            $display("tb_huffman_table_encoder: PASS");
        else
            $display("tb_huffman_table_encoder: FAIL");
        $finish;
    end
endmodule

>>> sim.f
rtl/hte_pkg.sv
rtl/hte_cmd_if.sv
rtl/hte_res_if.sv
rtl/hte_table.sv
rtl/hte_packer.sv
rtl/huffman_table_encoder.sv
tb/sv/hte_encode_checker.sv
tb/sv/tb_huffman_table_encoder.sv
